/* hdl/hghc_pkg.sv */
// shared types, constants and colour helpers for the heat grid hit counter
package hghc_pkg;

  localparam int PIX_BITS       = 12;
  localparam int OP_BITS        = 2;
  localparam int CELL_IDX_BITS  = 6;
  localparam int OUT_COUNT_BITS = 32;
  localparam int CH_BITS        = 8;
  localparam int CFG_ADDR_BITS  = 5;
  localparam int CFG_DATA_BITS  = 32;
  localparam int CELL_SIZE_BITS = 12;
  localparam int START_BITS     = 7;
  localparam int MODE_BITS      = 2;
  localparam int FX_FRAC_BITS   = 16;

  localparam int DEF_MAX_ROWS    = 64;
  localparam int DEF_MAX_COLUMNS = 64;
  localparam int DEF_COUNT_BITS  = 32;
  localparam int DEF_COORD_BITS  = 12;

  localparam logic [CELL_SIZE_BITS-1:0] RST_CELL_SIZE = 12'd16;
  localparam logic [START_BITS-1:0]     RST_START     = 7'd16;

  localparam logic [17:0] FX_ONE        = 18'd65536;
  localparam logic [17:0] FX_THIRD      = 18'd21845;
  localparam logic [17:0] FX_SIXTH      = 18'd10922;
  localparam logic [17:0] FX_HALF       = 18'd32768;
  localparam logic [17:0] FX_TWO_THIRDS = 18'd43690;

  typedef enum logic [OP_BITS-1:0] {
    OP_PRESS = 2'd0,
    OP_MOVE  = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  localparam logic [MODE_BITS-1:0] MODE_NO_PRESS = 2'd1;
  localparam logic [MODE_BITS-1:0] MODE_NO_MOVE  = 2'd2;

  localparam logic [2:0] REG_CELL_WIDTH  = 3'd0;
  localparam logic [2:0] REG_CELL_HEIGHT = 3'd1;
  localparam logic [2:0] REG_START_ROWS  = 3'd2;
  localparam logic [2:0] REG_START_COLS  = 3'd3;
  localparam logic [2:0] REG_INPUT_MODE  = 3'd4;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV,
    S_ADDR,
    S_RD,
    S_CDIV,
    S_DONE
  } state_t;

  function automatic logic [16:0] hue_term(input logic [17:0] t);
    logic [20:0] p;
    begin
      priority if (t < FX_SIXTH) p = 21'(t) * 21'd6;
      else if (t < FX_HALF) p = 21'(FX_ONE);
      else if (t < FX_TWO_THIRDS) p = 21'(FX_TWO_THIRDS - t) * 21'd6;
      else p = '0;
      return p[16:0];
    end
  endfunction

  // value * 255 / 65536
  function automatic logic [CH_BITS-1:0] to_channel(input logic [16:0] v);
    logic [24:0] p;
    begin
      p = {v, 8'b0} - 25'(v);
      return p[23:16];
    end
  endfunction

endpackage

/* hdl/hghc_if.sv */
// transaction channels of the heat grid hit counter
interface hghc_in_if;
  import hghc_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [OP_BITS-1:0]       op;
  logic [PIX_BITS-1:0]      pixel_x;
  logic [PIX_BITS-1:0]      pixel_y;
  logic [CELL_IDX_BITS-1:0] cell_row;
  logic [CELL_IDX_BITS-1:0] cell_column;
  modport source(output valid, op, pixel_x, pixel_y, cell_row, cell_column, input ready);
  modport sink(input valid, op, pixel_x, pixel_y, cell_row, cell_column, output ready);
endinterface

interface hghc_out_if;
  import hghc_pkg::*;
  logic                      valid;
  logic                      ready;
  logic                      counted;
  logic                      out_of_bounds;
  logic [CELL_IDX_BITS-1:0]  hit_row;
  logic [CELL_IDX_BITS-1:0]  hit_column;
  logic [OUT_COUNT_BITS-1:0] hit_count;
  logic [OUT_COUNT_BITS-1:0] peak_count;
  logic                      full_redraw;
  logic [CH_BITS-1:0]        red;
  logic [CH_BITS-1:0]        green;
  logic [CH_BITS-1:0]        blue;
  modport source(output valid, counted, out_of_bounds, hit_row, hit_column, hit_count,
                 peak_count, full_redraw, red, green, blue, input ready);
  modport sink(input valid, counted, out_of_bounds, hit_row, hit_column, hit_count,
               peak_count, full_redraw, red, green, blue, output ready);
endinterface

/* hdl/hghc_ram.sv */
// generic single-write, single-read ram with registered read data
module hghc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* hdl/hghc_sdiv.sv */
// bit-serial restoring divider, one quotient bit per cycle
module hghc_sdiv #(
  parameter int NUM_W = 12,
  parameter int DEN_W = 12
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);
  localparam int CW = $clog2(NUM_W + 1);

  logic             busy_r;
  logic             done_r;
  logic [CW-1:0]    cnt_r;
  logic [NUM_W-1:0] num_r;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W:0]   rem_r;
  logic [NUM_W-1:0] quo_r;
  logic [DEN_W:0]   shifted;
  logic             ge;
  logic [DEN_W:0]   rem_nxt;

  always_comb begin
    shifted = {rem_r[DEN_W-1:0], num_r[NUM_W-1]};
    ge      = shifted >= {1'b0, den_r};
    rem_nxt = ge ? shifted - {1'b0, den_r} : shifted;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(NUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
      den_r <= den;
      rem_r <= '0;
      quo_r <= '0;
    end else if (busy_r) begin
      num_r <= {num_r[NUM_W-2:0], 1'b0};
      rem_r <= rem_nxt;
      quo_r <= {quo_r[NUM_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign quo  = quo_r;
endmodule

/* hdl/heat_grid_hit_counter_core.sv */
// heat grid hit counter: per-cell pointer hit counts with hue colour readout
//
// in_if carries press, move and colour-read transactions; out_if returns one
// result per accepted transaction. An apb-style port (psel/penable/pwrite,
// pready tied high) sets cell size, start grid size and input mode; writing a
// start size clears the grid.
// A press or move runs a bit-serial pixel division, then a count ram read and
// write back. A colour read runs the count ram read, then a bit-serial
// count/peak division when the count and the peak are both nonzero.
// One transaction is worked on at a time; the next is taken as soon as the
// previous result sits in the output register.
// After reset, and after each start size write, a clearing pass zeroes the
// count ram one entry a cycle (MAX_ROWS * MAX_COLUMNS entries, 4096 by default)
// with in_if.ready low; configuration writes are still taken.
// If the receiver stalls, the result waits in the output register; a
// following result waits in the core until the output register frees.
module heat_grid_hit_counter_core #(
  parameter int MAX_ROWS    = hghc_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLUMNS = hghc_pkg::DEF_MAX_COLUMNS,
  parameter int COUNT_BITS  = hghc_pkg::DEF_COUNT_BITS,
  parameter int COORD_BITS  = hghc_pkg::DEF_COORD_BITS
) (
  input  logic                               clk,
  input  logic                               rst_n,
  hghc_in_if.sink                            in_if,
  hghc_out_if.source                         out_if,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [hghc_pkg::CFG_ADDR_BITS-1:0] paddr,
  input  logic [hghc_pkg::CFG_DATA_BITS-1:0] pwdata,
  output logic [hghc_pkg::CFG_DATA_BITS-1:0] prdata,
  output logic                               pready
);
  import hghc_pkg::*;

  localparam int DEPTH = MAX_ROWS * MAX_COLUMNS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int RI_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CI_W  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int AR_W  = $clog2(MAX_ROWS + 1);
  localparam int AC_W  = $clog2(MAX_COLUMNS + 1);
  localparam int CB    = COUNT_BITS;
  localparam int QW    = COUNT_BITS + FX_FRAC_BITS;
  localparam logic [PIX_BITS-1:0] PIX_MASK =
    (COORD_BITS >= PIX_BITS) ? '1 : PIX_BITS'((1 << COORD_BITS) - 1);
  localparam logic [CB-1:0]   CMAX     = '1;
  localparam logic [AR_W-1:0] RST_ROWS = (MAX_ROWS < 16) ? AR_W'(MAX_ROWS) : AR_W'(16);
  localparam logic [AC_W-1:0] RST_COLS = (MAX_COLUMNS < 16) ? AC_W'(MAX_COLUMNS) : AC_W'(16);

  // configuration
  logic [CELL_SIZE_BITS-1:0] cell_w_r, cell_h_r;
  logic [START_BITS-1:0]     start_rows_r, start_cols_r;
  logic [MODE_BITS-1:0]      mode_r;
  logic                      cfg_wr;
  logic [2:0]                reg_idx;
  logic                      reinit;
  logic [START_BITS-1:0]     sr_eff, sc_eff;
  logic [AR_W-1:0]           init_rows;
  logic [AC_W-1:0]           init_cols;

  // control and grid state
  state_t          state_r, state_nxt;
  logic [AW-1:0]   clr_cnt_r;
  logic [CB-1:0]   peak_r;
  logic [AR_W-1:0] act_rows_r;
  logic [AC_W-1:0] act_cols_r;
  logic            last_valid_r;
  logic [RI_W-1:0] last_row_r;
  logic [CI_W-1:0] last_col_r;
  logic            out_valid_r;

  // item registers
  op_t                  op_r;
  logic [PIX_BITS-1:0]  row_r, col_r;
  logic [AW-1:0]        addr_r;

  // result being built
  logic                     res_counted_r, res_oob_r, res_redraw_r, res_read_r;
  logic [CELL_IDX_BITS-1:0] res_row_r, res_col_r;
  logic [CB-1:0]            res_count_r, res_peak_r;
  logic [CH_BITS-1:0]       res_red_r, res_green_r, res_blue_r;

  // combinational
  logic            in_ready, in_acc, acc_ign;
  op_t             acc_op;
  logic            in_max;
  logic [AW-1:0]   addr;
  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  logic [CB-1:0]   ram_wdata, ram_rdata;
  logic            grow, mv_same, do_count;
  logic [CB-1:0]   newc;
  logic            pdiv_start, cdiv_start, out_load, out_free;
  logic            xdone, ydone, cdone;
  logic [PIX_BITS-1:0] qx, qy;
  logic [QW-1:0]   cquo;
  logic [16:0]     f17, h17;
  logic [17:0]     tr0, tr, tb;

  // configuration port
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign reg_idx = paddr[4:2];
  assign reinit  = cfg_wr && (reg_idx == REG_START_ROWS || reg_idx == REG_START_COLS);
  assign pready  = 1'b1;
  assign sr_eff  = (cfg_wr && reg_idx == REG_START_ROWS) ? pwdata[START_BITS-1:0] : start_rows_r;
  assign sc_eff  = (cfg_wr && reg_idx == REG_START_COLS) ? pwdata[START_BITS-1:0] : start_cols_r;

  always_comb begin
    priority if (sr_eff == '0) init_rows = AR_W'(1);
    else if (int'(sr_eff) > MAX_ROWS) init_rows = AR_W'(MAX_ROWS);
    else init_rows = AR_W'(sr_eff);
    priority if (sc_eff == '0) init_cols = AC_W'(1);
    else if (int'(sc_eff) > MAX_COLUMNS) init_cols = AC_W'(MAX_COLUMNS);
    else init_cols = AC_W'(sc_eff);
  end

  always_comb begin
    unique case (reg_idx)
      REG_CELL_WIDTH:  prdata = CFG_DATA_BITS'(cell_w_r);
      REG_CELL_HEIGHT: prdata = CFG_DATA_BITS'(cell_h_r);
      REG_START_ROWS:  prdata = CFG_DATA_BITS'(start_rows_r);
      REG_START_COLS:  prdata = CFG_DATA_BITS'(start_cols_r);
      REG_INPUT_MODE:  prdata = CFG_DATA_BITS'(mode_r);
      default:         prdata = '0;
    endcase
  end

  // input decode
  assign acc_op  = op_t'(in_if.op);
  assign in_acc  = in_if.valid & in_ready;
  assign acc_ign = (acc_op == OP_NONE) ||
                   (acc_op == OP_PRESS && mode_r == MODE_NO_PRESS) ||
                   (acc_op == OP_MOVE && mode_r == MODE_NO_MOVE);

  // cell address and bounds
  assign in_max = (row_r < PIX_BITS'(MAX_ROWS)) && (col_r < PIX_BITS'(MAX_COLUMNS));
  assign addr   = AW'(row_r[RI_W-1:0]) * AW'(MAX_COLUMNS) + AW'(col_r[CI_W-1:0]);

  // event update, valid in S_RD
  always_comb begin
    grow     = (row_r >= PIX_BITS'(act_rows_r)) || (col_r >= PIX_BITS'(act_cols_r));
    mv_same  = !grow && op_r == OP_MOVE && last_valid_r &&
               row_r[RI_W-1:0] == last_row_r && col_r[CI_W-1:0] == last_col_r;
    do_count = !mv_same && ram_rdata != CMAX;
    newc     = do_count ? ram_rdata + CB'(1) : ram_rdata;
  end

  // colour from count/peak quotient
  always_comb begin
    f17 = (cquo > QW'(FX_ONE)) ? 17'(FX_ONE) : cquo[16:0];
    h17 = 17'(FX_ONE - 18'(f17));
    tr0 = 18'(h17) + FX_THIRD;
    tr  = (tr0 > FX_ONE) ? tr0 - FX_ONE : tr0;
    tb  = (18'(h17) >= FX_THIRD) ? 18'(h17) - FX_THIRD : 18'(h17) + FX_ONE - FX_THIRD;
  end

  assign out_free = !out_valid_r || out_if.ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: if (clr_cnt_r == AW'(DEPTH - 1)) state_nxt = S_IDLE;
      S_IDLE: begin
        if (in_acc) begin
          priority if (acc_op == OP_READ) state_nxt = S_ADDR;
          else if (acc_ign) state_nxt = S_DONE;
          else state_nxt = S_DIV;
        end
      end
      S_DIV:  if (ydone) state_nxt = S_ADDR;
      S_ADDR: state_nxt = in_max ? S_RD : S_DONE;
      S_RD: begin
        if (op_r == OP_READ && ram_rdata != '0 && peak_r != '0) state_nxt = S_CDIV;
        else state_nxt = S_DONE;
      end
      S_CDIV: if (cdone) state_nxt = S_DONE;
      S_DONE: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
    if (reinit) state_nxt = S_CLEAR;
  end

  // fsm outputs
  always_comb begin
    in_ready   = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = addr_r;
    ram_wdata  = newc;
    pdiv_start = 1'b0;
    cdiv_start = 1'b0;
    out_load   = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_r;
        ram_wdata = '0;
      end
      S_IDLE:  begin
        in_ready   = 1'b1;
        pdiv_start = in_acc && acc_op != OP_READ && !acc_ign;
      end
      S_RD: begin
        ram_we     = op_r != OP_READ && do_count;
        cdiv_start = op_r == OP_READ && ram_rdata != '0 && peak_r != '0;
      end
      S_DONE: out_load = out_free;
      default: ;
    endcase
  end

  assign in_if.ready = in_ready;

  hghc_ram #(.WIDTH(CB), .DEPTH(DEPTH)) u_counts (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(addr),
    .rdata(ram_rdata)
  );

  hghc_sdiv #(.NUM_W(PIX_BITS), .DEN_W(CELL_SIZE_BITS)) u_div_x (
    .clk  (clk),
    .rst_n(rst_n),
    .start(pdiv_start),
    .num  (in_if.pixel_x & PIX_MASK),
    .den  ((cell_w_r == '0) ? CELL_SIZE_BITS'(1) : cell_w_r),
    .done (xdone),
    .quo  (qx)
  );

  hghc_sdiv #(.NUM_W(PIX_BITS), .DEN_W(CELL_SIZE_BITS)) u_div_y (
    .clk  (clk),
    .rst_n(rst_n),
    .start(pdiv_start),
    .num  (in_if.pixel_y & PIX_MASK),
    .den  ((cell_h_r == '0) ? CELL_SIZE_BITS'(1) : cell_h_r),
    .done (ydone),
    .quo  (qy)
  );

  // the divider takes the count straight from the ram read in S_RD
  hghc_sdiv #(.NUM_W(QW), .DEN_W(CB)) u_div_c (
    .clk  (clk),
    .rst_n(rst_n),
    .start(cdiv_start),
    .num  ({ram_rdata, 16'b0}),
    .den  (peak_r),
    .done (cdone),
    .quo  (cquo)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_cnt_r    <= '0;
      peak_r       <= '0;
      act_rows_r   <= RST_ROWS;
      act_cols_r   <= RST_COLS;
      last_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      cell_w_r     <= RST_CELL_SIZE;
      cell_h_r     <= RST_CELL_SIZE;
      start_rows_r <= RST_START;
      start_cols_r <= RST_START;
      mode_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR && !reinit) clr_cnt_r <= clr_cnt_r + AW'(1);
      if (out_load) out_valid_r <= 1'b1;
      else if (out_if.ready) out_valid_r <= 1'b0;
      if (cfg_wr) begin
        unique case (reg_idx)
          REG_CELL_WIDTH:  cell_w_r <= pwdata[CELL_SIZE_BITS-1:0];
          REG_CELL_HEIGHT: cell_h_r <= pwdata[CELL_SIZE_BITS-1:0];
          REG_START_ROWS:  start_rows_r <= pwdata[START_BITS-1:0];
          REG_START_COLS:  start_cols_r <= pwdata[START_BITS-1:0];
          REG_INPUT_MODE:  mode_r <= pwdata[MODE_BITS-1:0];
          default: ;
        endcase
      end
      if (reinit) begin
        clr_cnt_r    <= '0;
        peak_r       <= '0;
        act_rows_r   <= init_rows;
        act_cols_r   <= init_cols;
        last_valid_r <= 1'b0;
      end else if (state_r == S_RD && op_r != OP_READ) begin
        if (do_count && newc > peak_r) peak_r <= newc;
        if (row_r >= PIX_BITS'(act_rows_r)) act_rows_r <= AR_W'(row_r[RI_W-1:0]) + AR_W'(1);
        if (col_r >= PIX_BITS'(act_cols_r)) act_cols_r <= AC_W'(col_r[CI_W-1:0]) + AC_W'(1);
        if (!grow && op_r == OP_MOVE && !mv_same) begin
          last_valid_r <= 1'b1;
          last_row_r   <= row_r[RI_W-1:0];
          last_col_r   <= col_r[CI_W-1:0];
        end
      end
    end
  end

  // item and result registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          op_r          <= acc_op;
          row_r         <= PIX_BITS'(in_if.cell_row);
          col_r         <= PIX_BITS'(in_if.cell_column);
          res_read_r    <= acc_op == OP_READ;
          res_counted_r <= 1'b0;
          res_oob_r     <= 1'b0;
          res_redraw_r  <= 1'b0;
          res_row_r     <= '0;
          res_col_r     <= '0;
          res_count_r   <= '0;
          res_peak_r    <= peak_r;
          res_red_r     <= '0;
          res_green_r   <= '0;
          res_blue_r    <= '0;
        end
      end
      S_DIV: begin
        if (ydone) begin
          row_r <= qy;
          col_r <= qx;
        end
      end
      S_ADDR: begin
        addr_r    <= addr;
        res_row_r <= row_r[CELL_IDX_BITS-1:0];
        res_col_r <= col_r[CELL_IDX_BITS-1:0];
        if (!in_max) begin
          // dropped event, or read outside the grid reads as an empty cell
          res_oob_r <= op_r != OP_READ;
          if (op_r == OP_READ) begin
            res_red_r   <= '1;
            res_green_r <= '1;
            res_blue_r  <= '1;
          end
        end
      end
      S_RD: begin
        if (op_r == OP_READ) begin
          res_count_r <= ram_rdata;
          if (ram_rdata == '0 || peak_r == '0) begin
            res_red_r   <= '1;
            res_green_r <= '1;
            res_blue_r  <= '1;
          end
        end else begin
          res_counted_r <= do_count;
          res_count_r   <= newc;
          res_redraw_r  <= do_count && newc > peak_r;
          res_peak_r    <= (do_count && newc > peak_r) ? newc : peak_r;
        end
      end
      S_CDIV: begin
        if (cdone) begin
          res_red_r   <= to_channel(hue_term(tr));
          res_green_r <= to_channel(hue_term(18'(h17)));
          res_blue_r  <= to_channel(hue_term(tb));
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_if.counted       <= res_counted_r;
      out_if.out_of_bounds <= res_oob_r;
      out_if.hit_row       <= res_row_r;
      out_if.hit_column    <= res_col_r;
      out_if.hit_count     <= OUT_COUNT_BITS'(res_count_r);
      out_if.peak_count    <= OUT_COUNT_BITS'(res_peak_r);
      out_if.full_redraw   <= res_redraw_r;
      out_if.red           <= res_red_r;
      out_if.green         <= res_green_r;
      out_if.blue          <= res_blue_r;
    end
  end

  assign out_if.valid = out_valid_r;

`ifndef SYNTHESIS
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CLEAR |-> !in_if.ready)
    else $error("input taken during clearing pass");

  a_peak_covers_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RD && ram_we) |=> peak_r >= $past(ram_wdata))
    else $error("peak below a written count");

  a_empty_read_white: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && res_read_r && res_count_r == '0) |=>
      (out_if.red == '1 && out_if.green == '1 && out_if.blue == '1))
    else $error("empty cell read not white");

  a_div_pair: assert property (@(posedge clk) disable iff (!rst_n)
    xdone == ydone)
    else $error("pixel dividers out of step");
`endif
endmodule
